// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros for the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another at the same edge.
`define ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
	else $error("implication check failed");

// Check that a condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("invariant check failed");

`endif

// ===== rtl/core/srs_pkg.sv =====
package srs_pkg;
	localparam int unsigned MaxKeysDefault = 64;
	localparam int unsigned KeyW = 32;
	localparam int unsigned PosW = 6;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic [PosW-1:0] pos;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_OUT_RD,
		ST_OUT_SHOW
	} state_t;

	function automatic logic key_greater(logic [KeyW-1:0] a, logic [KeyW-1:0] b);
		return $signed(a) > $signed(b);
	endfunction
endpackage

// ===== rtl/core/srs_if.sv =====
interface srs_key_if;
	logic                        valid;
	logic                        ready;
	logic [srs_pkg::KeyW-1:0]    key;
	logic                        last_key;
	modport source (output valid, key, last_key, input ready);
	modport sink   (input valid, key, last_key, output ready);
endinterface

interface srs_rank_if;
	logic                        valid;
	logic                        ready;
	logic [srs_pkg::PosW-1:0]    rank_index;
	logic                        last_rank;
	logic                        overflow;
	modport source (output valid, rank_index, last_rank, overflow, input ready);
	modport sink   (input valid, rank_index, last_rank, overflow, output ready);
endinterface

// ===== rtl/core/stable_rank_sorter.sv =====
// Channel | Dir | Payload                                | Transfer
// keys    | in  | key[31:0] signed, last_key             | valid && ready
// ranks   | out | rank_index[5:0], last_rank, overflow   | valid && ready
//
// A key into an empty store is written at once; a key into a full store is dropped.
// Otherwise the transfer is followed by a shift walk that moves each larger entry
// up one slot, then places the key.
// Results: one memory read after the run ends, then one result per output transfer.
// arst_n clears the count, overflow flag and state; memory contents stay undefined.
// keys.ready is low while a key is inserted and while results are drained.
`include "assert_macros.svh"

module stable_rank_sorter #(
	parameter int unsigned MAX_KEYS = srs_pkg::MaxKeysDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	srs_key_if.sink          keys,
	srs_rank_if.source       ranks
);
	localparam int unsigned AW = $clog2(MAX_KEYS);
	localparam int unsigned CW = $clog2(MAX_KEYS + 1);
	localparam logic [CW-1:0] CntMax = CW'(MAX_KEYS);

	// Sorted entries: key plus arrival position, ascending by key.
	srs_pkg::entry_t mem [MAX_KEYS];
	srs_pkg::entry_t rd_q;

	srs_pkg::state_t state_q, state_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic           drop_q, drop_d;
	logic [AW-1:0]  idx_q, idx_d;     // walk / drain index
	logic [srs_pkg::KeyW-1:0] k_q;    // key under insertion
	logic           last_q;           // insertion ends the run

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	srs_pkg::entry_t wr_data;
	logic [AW-1:0]  rd_addr;
	logic           in_xfer, out_xfer, out_end;
	logic [AW-1:0]  top_idx;

	assign in_xfer  = keys.valid && keys.ready;
	assign out_xfer = ranks.valid && ranks.ready;
	assign top_idx  = AW'(cnt_q - CW'(1));
	assign out_end  = (idx_q == top_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srs_pkg::ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			idx_q   <= idx_d;
		end
	end

	// Hold the incoming key for the shift walk.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			k_q    <= keys.key;
			last_q <= keys.last_key;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		drop_d      = drop_q;
		idx_d       = idx_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '{key: k_q, pos: srs_pkg::PosW'(cnt_q)};
		rd_addr     = idx_q;
		keys.ready  = 1'b0;
		ranks.valid = 1'b0;
		unique case (state_q)
			srs_pkg::ST_IDLE: begin
				keys.ready = 1'b1;
				if (in_xfer) begin
					if (cnt_q == CntMax) begin
						// Store full: drop the key, still honor the run end.
						drop_d = 1'b1;
						if (keys.last_key) begin
							idx_d   = '0;
							state_d = srs_pkg::ST_OUT_RD;
						end
					end else if (cnt_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = '{key: keys.key, pos: '0};
						cnt_d   = CW'(1);
						if (keys.last_key) begin
							idx_d   = '0;
							state_d = srs_pkg::ST_OUT_RD;
						end
					end else begin
						// Start the walk at the top entry.
						rd_addr = top_idx;
						idx_d   = top_idx;
						state_d = srs_pkg::ST_SHIFT;
					end
				end
			end
			srs_pkg::ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = AW'({1'b0, idx_q} + 1'b1);
				if (srs_pkg::key_greater(rd_q.key, k_q)) begin
					// Move the larger entry up one slot.
					wr_data = rd_q;
					if (idx_q == '0) begin
						// Everything moved; place the new key on the next cycle.
						state_d = srs_pkg::ST_PLACE;
						idx_d   = '0;
					end else begin
						rd_addr = idx_q - AW'(1);
						idx_d   = idx_q - AW'(1);
					end
				end
				// Place the new key above the first entry not greater than it.
				if (!srs_pkg::key_greater(rd_q.key, k_q)) begin
					cnt_d = cnt_q + CW'(1);
					idx_d = '0;
					state_d = last_q ? srs_pkg::ST_OUT_RD : srs_pkg::ST_IDLE;
				end
			end
			srs_pkg::ST_PLACE: begin
				// New key is the smallest: it goes to the bottom slot.
				wr_en   = 1'b1;
				wr_addr = '0;
				cnt_d   = cnt_q + CW'(1);
				idx_d   = '0;
				state_d = last_q ? srs_pkg::ST_OUT_RD : srs_pkg::ST_IDLE;
			end
			srs_pkg::ST_OUT_RD: begin
				state_d = srs_pkg::ST_OUT_SHOW;
			end
			srs_pkg::ST_OUT_SHOW: begin
				ranks.valid = 1'b1;
				if (out_xfer) begin
					if (out_end) begin
						cnt_d   = '0;
						drop_d  = 1'b0;
						idx_d   = '0;
						state_d = srs_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						rd_addr = idx_q + AW'(1);
						state_d = srs_pkg::ST_OUT_SHOW;
					end
				end
			end
			default: begin
				state_d = srs_pkg::ST_IDLE;
			end
		endcase
	end

	assign ranks.rank_index = rd_q.pos;
	assign ranks.last_rank  = out_end;
	assign ranks.overflow   = drop_q;

	`ASSERT_IMPLY(a_out_has_keys, ranks.valid, cnt_q != '0)
	`ASSERT_IMPLY(a_no_overlap, keys.ready, !ranks.valid)
	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntMax)
endmodule
